// File: hdl/utf8_stream_validator_core_assert.svh
// Assertion macros for the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define USV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define USV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/usv_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
package usv_pkg;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [CfgAddrWidth-1:0] RegAsciiOnly = 3'd0;

  localparam logic [7:0] Lead2Lo  = 8'hC2;
  localparam logic [7:0] Lead2Hi  = 8'hDF;
  localparam logic [7:0] Lead3Lo  = 8'hE0;
  localparam logic [7:0] Lead3Hi  = 8'hEF;
  localparam logic [7:0] Lead4Lo  = 8'hF0;
  localparam logic [7:0] Lead4Hi  = 8'hF4;
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [7:0] AsciiLim = 8'h80;

  localparam logic [20:0] CpMax    = 21'h10FFFF;
  localparam logic [20:0] SurrLo   = 21'h00D800;
  localparam logic [20:0] SurrHi   = 21'h00DFFF;
  localparam logic [20:0] CpMinLen1 = 21'd128;
  localparam logic [20:0] CpMinLen2 = 21'd2048;
  localparam logic [20:0] CpMinLen3 = 21'd65536;

  localparam logic [1:0] SeqLen1 = 2'd1;
  localparam logic [1:0] SeqLen2 = 2'd2;
  localparam logic [1:0] SeqLen3 = 2'd3;

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic [20:0] code_point;
    logic [1:0]  sequence_length;
    logic        error_seen;
  } usv_state_t;

endpackage

// File: hdl/usv_if.sv
// Stream interfaces for the text byte input and the verdict output.
interface usv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface usv_out_if;
  logic valid;
  logic ready;
  logic string_valid;

  modport source (output valid, output string_valid, input ready);
  modport sink (input valid, input string_valid, output ready);
endinterface

// File: hdl/usv_decode.sv
// Per-byte UTF-8 decode step: next string state and verdict for one byte.
module usv_decode (
  input  usv_pkg::usv_state_t st,
  input  logic [7:0]          text_byte,
  input  logic                last_byte,
  input  logic                ascii_only,
  output usv_pkg::usv_state_t st_next,
  output logic                string_valid
);
  import usv_pkg::*;

  usv_state_t  step;
  logic [20:0] cp_acc;
  logic [1:0]  pend_dec;
  logic [20:0] cp_min;

  assign cp_acc   = {st.code_point[14:0], text_byte[5:0]};
  assign pend_dec = st.bytes_pending - 2'd1;

  always_comb begin
    unique case (st.sequence_length)
      SeqLen1: cp_min = CpMinLen1;
      SeqLen2: cp_min = CpMinLen2;
      default: cp_min = CpMinLen3;
    endcase
  end

  always_comb begin
    step = st;
    if (st.error_seen) begin
      step = st;
    end else if (text_byte == 8'h00) begin
      step.error_seen = 1'b1;
    end else if (st.bytes_pending != 2'd0) begin
      if (text_byte[7:6] != ContTag) begin
        step.error_seen = 1'b1;
      end else if (pend_dec != 2'd0) begin
        step.code_point    = cp_acc;
        step.bytes_pending = pend_dec;
      end else begin
        step.bytes_pending   = 2'd0;
        step.code_point      = '0;
        step.sequence_length = 2'd0;
        if (cp_acc < cp_min || cp_acc > CpMax || (cp_acc >= SurrLo && cp_acc <= SurrHi)) begin
          step.error_seen = 1'b1;
        end
      end
    end else if (text_byte < AsciiLim) begin
      step = st;
    end else if (ascii_only) begin
      step.error_seen = 1'b1;
    end else if (text_byte >= Lead2Lo && text_byte <= Lead2Hi) begin
      step.sequence_length = SeqLen1;
      step.bytes_pending   = SeqLen1;
      step.code_point      = {16'd0, text_byte[4:0]};
    end else if (text_byte >= Lead3Lo && text_byte <= Lead3Hi) begin
      step.sequence_length = SeqLen2;
      step.bytes_pending   = SeqLen2;
      step.code_point      = {17'd0, text_byte[3:0]};
    end else if (text_byte >= Lead4Lo && text_byte <= Lead4Hi) begin
      step.sequence_length = SeqLen3;
      step.bytes_pending   = SeqLen3;
      step.code_point      = {18'd0, text_byte[2:0]};
    end else begin
      step.error_seen = 1'b1;
    end
  end

  always_comb begin
    string_valid = !(step.error_seen || step.bytes_pending != 2'd0);
    if (last_byte) begin
      st_next = '0;
    end else begin
      st_next = step;
    end
  end

endmodule

// File: hdl/utf8_stream_validator_core.sv
// Top level of the UTF-8 stream validator: input stage, decode, verdict register, APB port.
//
//   channel   | dir | payload                  | word
//   text      | in  | text_byte[7:0], last_byte| one byte of the string
//   verdict   | out | string_valid             | one per string, on its last byte
//   apb       | in  | paddr[2:0], pwdata[31:0] | ascii_only at addresses 0 to 3
//
// One byte is taken every cycle unless stalled; the last byte's verdict is registered.
// The input stage stalls only when it holds a last byte while the verdict register
// still holds an untaken verdict.
// rst clears the string state, the stage valid bits and ascii_only.
module utf8_stream_validator_core (
  input  logic                               clk,
  input  logic                               rst,
  usv_in_if.sink                             text,
  usv_out_if.source                          verdict,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [usv_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [usv_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [usv_pkg::CfgDataWidth-1:0]   prdata,
  output logic                               pready
);
  import usv_pkg::*;

  logic       ascii_only;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_advance;
  logic       out_valid;
  logic       out_string_valid;
  logic       dec_valid;
  usv_state_t st;
  usv_state_t st_next;

  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrWidth-1] == RegAsciiOnly[CfgAddrWidth-1]) ?
                  {{(CfgDataWidth-1){1'b0}}, ascii_only} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_only <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CfgAddrWidth-1] == RegAsciiOnly[CfgAddrWidth-1]) begin
      ascii_only <= pwdata[0];
    end
  end

  assign s1_advance = s1_valid && (!s1_last || !out_valid || verdict.ready);
  assign text.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_byte <= text.text_byte;
      s1_last <= text.last_byte;
    end
  end

  usv_decode u_decode (
    .st           (st),
    .text_byte    (s1_byte),
    .last_byte    (s1_last),
    .ascii_only   (ascii_only),
    .st_next      (st_next),
    .string_valid (dec_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      out_string_valid <= dec_valid;
    end
  end

  assign verdict.valid        = out_valid;
  assign verdict.string_valid = out_string_valid;

  `include "utf8_stream_validator_core_assert.svh"

  `USV_ASSERT_NEXT(a_verdict_loaded, s1_advance && s1_last, out_valid, "verdict not loaded")
  `USV_ASSERT_NEXT(a_state_cleared, s1_advance && s1_last, st == '0, "state not cleared")
  `USV_ASSERT_SAME(a_pending_bound, 1'b1, st.bytes_pending <= st.sequence_length, "pending beyond length")
  `USV_ASSERT_SAME(a_stall_cause, !text.ready, s1_valid && s1_last && out_valid && !verdict.ready, "unexpected stall")

endmodule

// File: bench/usv_string_checker.sv
// UTF-8 validator checker: predicts each string verdict, checks ascii_only readback.
module usv_string_checker (
  input  logic                             clk,
  input  logic                             rst,
  usv_in_if                                text,
  usv_out_if                               verdict,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [usv_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [usv_pkg::CfgDataWidth-1:0] pwdata,
  input  logic [usv_pkg::CfgDataWidth-1:0] prdata,
  output int unsigned                      fail_count,
  output int unsigned                      pending,
  output int unsigned                      checked
);
  import usv_pkg::*;

  logic        ascii_only;
  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  logic [1:0]  seq_len;
  logic        err_seen;
  logic        verdict_q[$];

  function automatic void clear_string();
    cont_left = '0;
    cp_acc    = '0;
    seq_len   = '0;
    err_seen  = 1'b0;
  endfunction

  function automatic logic [20:0] min_code(input logic [1:0] len);
    if (len == SeqLen1) begin
      return CpMinLen1;
    end
    if (len == SeqLen2) begin
      return CpMinLen2;
    end
    return CpMinLen3;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (err_seen) begin
      return;
    end
    if (b == 8'h00) begin
      err_seen = 1'b1;
      return;
    end
    if (cont_left != 2'd0) begin
      if (b[7:6] != ContTag) begin
        err_seen = 1'b1;
        return;
      end
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (cp_acc < min_code(seq_len) || cp_acc > CpMax ||
            (cp_acc >= SurrLo && cp_acc <= SurrHi)) begin
          err_seen = 1'b1;
        end
        cp_acc  = '0;
        seq_len = '0;
      end
      return;
    end
    if (b < AsciiLim) begin
      return;
    end
    if (ascii_only) begin
      err_seen = 1'b1;
      return;
    end
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      seq_len = SeqLen1;
      cp_acc  = {16'd0, b[4:0]};
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      seq_len = SeqLen2;
      cp_acc  = {17'd0, b[3:0]};
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      seq_len = SeqLen3;
      cp_acc  = {18'd0, b[2:0]};
    end else begin
      err_seen = 1'b1;
      return;
    end
    cont_left = seq_len;
  endfunction

  function automatic void flag(input string what, input logic [31:0] expd,
                               input logic [31:0] got);
    if (fail_count < 10) begin
      $display("MISMATCH %s at %0t: expected %0h, got %0h", what, $realtime, expd, got);
    end
    fail_count++;
  endfunction

  always @(posedge clk) begin : watch
    logic want;
    if (rst) begin
      clear_string();
      ascii_only = 1'b0;
      verdict_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (verdict.valid && verdict.ready) begin
        if (verdict_q.size() == 0) begin
          flag("verdict with no string waiting", 32'hx, {31'd0, verdict.string_valid});
        end else begin
          want = verdict_q.pop_front();
          checked++;
          if (verdict.string_valid !== want) begin
            flag("string_valid", {31'd0, want}, {31'd0, verdict.string_valid});
          end
        end
      end
      if (text.valid && text.ready) begin
        take_byte(text.text_byte);
        if (text.last_byte) begin
          if (cont_left != 2'd0) begin
            err_seen = 1'b1;
          end
          verdict_q.push_back(!err_seen);
          clear_string();
        end
      end
      if (psel && penable && pready && paddr == RegAsciiOnly) begin
        if (pwrite) begin
          ascii_only = pwdata[0];
        end else if (prdata !== {31'd0, ascii_only}) begin
          flag("ascii_only readback", {31'd0, ascii_only}, prdata);
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Testbench top for the UTF-8 stream validator: stimulus, receiver, watchdog and verdict.
module tb_top;
  import usv_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic                    pready;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned n_bytes;
  int unsigned n_strings;
  int unsigned n_writes;
  bit          ascii_mode;
  logic [7:0]  str_buf[$];

  usv_in_if  text_ch();
  usv_out_if verdict_ch();

  always #5 clk = ~clk;

  utf8_stream_validator_core dut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .verdict (verdict_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  usv_string_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .text       (text_ch),
    .verdict    (verdict_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(negedge clk) begin
    if (hold_left != 0) begin
      verdict_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      verdict_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no handshake in %0d cycles", StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.last_byte <= last;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
    n_bytes++;
    if (last) begin
      n_strings++;
    end
  endtask

  task automatic send_word(input int n, input logic [31:0] w, input bit ends);
    int i;
    for (i = 0; i < n; i++) begin
      push_byte(w[31-8*i -: 8], ends && i == n - 1);
    end
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < str_buf.size(); i++) begin
      push_byte(str_buf[i], i == str_buf.size() - 1);
    end
    str_buf.delete();
  endtask

  task automatic apb_access(input bit wr, input logic [CfgDataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RegAsciiOnly;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // drain in-flight bytes before touching the mode
  task automatic set_ascii(input bit v);
    text_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    apb_access(1'b1, {31'd0, v});
    apb_access(1'b0, '0);
    ascii_mode = v;
    n_writes++;
  endtask

  function automatic logic [31:0] utf8_encode(input logic [20:0] cp, input int n);
    case (n)
      1: return {cp[7:0], 24'h0};
      2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
    endcase
  endfunction

  task automatic add_char(input bit clean);
    int          kind;
    int          n;
    int          drop;
    int          spoil_at;
    int          i;
    logic [20:0] cp;
    logic [31:0] enc;
    logic [7:0]  b;
    n        = 1;
    drop     = 0;
    spoil_at = -1;
    if (ascii_mode && $urandom_range(99) < 70) begin
      kind = 0;
    end else begin
      kind = clean ? $urandom_range(79) : $urandom_range(99);
    end
    if (kind < 40) begin
      cp = 21'($urandom_range(1, 127));
    end else if (kind < 55) begin
      n  = 2;
      cp = 21'($urandom_range(128, 2047));
    end else if (kind < 70) begin
      n  = 3;
      cp = 21'($urandom_range(2048, 65535));
      if (cp >= SurrLo && cp <= SurrHi) begin
        cp ^= 21'h2000;
      end
    end else if (kind < 80) begin
      n  = 4;
      cp = 21'($urandom_range(65536, 21'h10FFFF));
    end else if (kind < 84) begin
      n  = $urandom_range(2, 4);
      cp = 21'($urandom_range(0, (n == 2) ? 127 : (n == 3) ? 2047 : 65535));
    end else if (kind < 87) begin
      n  = 3;
      cp = 21'($urandom_range(SurrLo, SurrHi));
    end else if (kind < 90) begin
      n  = 4;
      cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
    end else if (kind < 96) begin
      n  = $urandom_range(2, 4);
      cp = 21'((n == 2) ? $urandom_range(128, 2047) :
               (n == 3) ? $urandom_range(2048, 55295) :
                          $urandom_range(65536, 21'h10FFFF));
      if (kind < 93) begin
        drop = $urandom_range(1, n - 1);
      end else begin
        spoil_at = $urandom_range(1, n - 1);
      end
    end else if (kind < 98) begin
      cp = 21'($urandom_range(0, 255));
    end else begin
      cp = '0;
    end
    enc = utf8_encode(cp, n);
    for (i = 0; i < n - drop; i++) begin
      b = enc[31-8*i -: 8];
      if (i == spoil_at) begin
        b = 8'($urandom_range(255));
      end
      str_buf.push_back(b);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    bit          clean;
    stop_at = n_bytes + count;
    while (n_bytes < stop_at) begin
      clean = ($urandom_range(99) < 55);
      repeat ($urandom_range(1, 6)) add_char(clean);
      send_buffer();
    end
  endtask

  initial begin
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.last_byte = 1'b0;
    verdict_ch.ready  = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_idle_pct       = 15;
    out_idle_pct      = 65;
    hold_left         = 0;
    quiet_cycles      = 0;
    n_bytes           = 0;
    n_strings         = 0;
    n_writes          = 0;
    ascii_mode        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_ascii(1'b0);
    send_word(1, 32'h4100_0000, 1);
    send_word(1, 32'h7F00_0000, 1);
    send_word(1, 32'h0000_0000, 1);
    send_word(2, 32'hC280_0000, 1);
    send_word(2, 32'hDFBF_0000, 1);
    send_word(2, 32'hC1BF_0000, 1);
    send_word(1, 32'h8000_0000, 1);
    send_word(3, 32'hE0A0_8000, 1);
    send_word(3, 32'hE09F_BF00, 1);
    send_word(3, 32'hED9F_BF00, 1);
    send_word(3, 32'hEDA0_8000, 1);
    send_word(3, 32'hEDBF_BF00, 1);
    send_word(4, 32'hF090_8080, 1);
    send_word(4, 32'hF08F_BFBF, 1);
    send_word(4, 32'hF48F_BFBF, 1);
    send_word(4, 32'hF490_8080, 1);
    send_word(4, 32'hF580_8080, 1);
    send_word(1, 32'hFF00_0000, 1);
    send_word(2, 32'hE282_0000, 1);
    send_word(2, 32'hC341_0000, 1);
    send_word(2, 32'hC300_0000, 1);
    send_word(3, 32'h0041_C300, 1);
    // flip the mode between a lead byte and its continuation
    send_word(1, 32'hC300_0000, 0);
    set_ascii(1'b1);
    send_word(1, 32'hA900_0000, 1);
    send_word(1, 32'hE900_0000, 1);
    send_word(2, 32'h417F_0000, 1);
    send_word(1, 32'h4100_0000, 0);
    set_ascii(1'b0);
    send_word(2, 32'hC3A9_0000, 1);

    run_random(350);
    set_ascii(1'b1);
    run_random(120);

    in_idle_pct  = 65;
    out_idle_pct = 15;
    set_ascii(1'b0);
    run_random(350);
    set_ascii(1'b1);
    run_random(120);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_ascii(1'b0);
    run_random(300);
    // hold the verdict side while strings keep coming
    hold_left = 80;
    repeat (30) begin
      add_char(1'b1);
      send_buffer();
    end
    set_ascii(1'b1);
    run_random(100);

    text_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Covered %0d strings, %0d bytes, %0d mode writes, %0d verdicts checked",
             n_strings, n_bytes, n_writes, checked);
    $display("Stimulus: UTF-8 edge cases, random valid and broken sequences, both modes, %s",
             "varied idling and a long receiver hold");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
